// ----- sv/imbe_pkg.sv -----
package imbe_pkg;

    // Field and register widths
    localparam int DATA_W  = 8;
    localparam int HALF_W  = 16;
    localparam int REC_W   = 4;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RECOVER = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_CNT = 1'd1;

    // Register reset values
    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [REC_W-1:0]  RECOVER_CNT_RESET = 4'd9;

endpackage

// ----- sv/i2c_master_byte_engine_top.sv -----
// The result for a tick request is registered and shown in the cycle after acceptance.
// Throughput: one tick request per clock cycle while no result is stalled; the state machine takes
// one micro-step per tick, so a byte command spans many requests, paced by the delay and stretch steps.
// Reset (rst_n low, asynchronous): engine idle, SCL and SDA released, read data and NACK
// flag cleared, half period 100 ticks, recovery count 9, no result pending.
module i2c_master_byte_engine_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [imbe_pkg::CMD_W-1:0]          cmd,
    input  logic [imbe_pkg::DATA_W-1:0]         write_data,
    input  logic                                want_start,
    input  logic                                want_stop,
    input  logic                                send_nack,
    input  logic                                sda_in,
    input  logic                                scl_in,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                scl_out,
    output logic                                sda_out,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [imbe_pkg::DATA_W-1:0]         read_data,
    output logic                                got_nack,
    // configuration
    input  logic                                cfg_we,
    input  logic [imbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imbe_pkg::HALF_W-1:0]         cfg_data
);

    localparam int PH_W = 5;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    localparam logic [PH_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PH_W-1:0] PH_RS_SDA_H = 5'd1;
    localparam logic [PH_W-1:0] PH_RS_D1    = 5'd2;
    localparam logic [PH_W-1:0] PH_RS_SCL_H = 5'd3;
    localparam logic [PH_W-1:0] PH_RS_STR   = 5'd4;
    localparam logic [PH_W-1:0] PH_RS_D2    = 5'd5;
    localparam logic [PH_W-1:0] PH_ST_SDA_L = 5'd6;
    localparam logic [PH_W-1:0] PH_ST_D     = 5'd7;
    localparam logic [PH_W-1:0] PH_ST_SCL_L = 5'd8;
    localparam logic [PH_W-1:0] PH_WB_SDA   = 5'd9;
    localparam logic [PH_W-1:0] PH_WB_D1    = 5'd10;
    localparam logic [PH_W-1:0] PH_WB_SCL_H = 5'd11;
    localparam logic [PH_W-1:0] PH_WB_D2    = 5'd12;
    localparam logic [PH_W-1:0] PH_WB_STR   = 5'd13;
    localparam logic [PH_W-1:0] PH_WB_SCL_L = 5'd14;
    localparam logic [PH_W-1:0] PH_RB_SDA_H = 5'd15;
    localparam logic [PH_W-1:0] PH_RB_D1    = 5'd16;
    localparam logic [PH_W-1:0] PH_RB_SCL_H = 5'd17;
    localparam logic [PH_W-1:0] PH_RB_STR   = 5'd18;
    localparam logic [PH_W-1:0] PH_RB_D2    = 5'd19;
    localparam logic [PH_W-1:0] PH_RB_SMP   = 5'd20;
    localparam logic [PH_W-1:0] PH_SP_SDA_L = 5'd21;
    localparam logic [PH_W-1:0] PH_SP_D1    = 5'd22;
    localparam logic [PH_W-1:0] PH_SP_SCL_H = 5'd23;
    localparam logic [PH_W-1:0] PH_SP_STR   = 5'd24;
    localparam logic [PH_W-1:0] PH_SP_D2    = 5'd25;
    localparam logic [PH_W-1:0] PH_SP_SDA_H = 5'd26;
    localparam logic [PH_W-1:0] PH_SP_D3    = 5'd27;
    localparam logic [PH_W-1:0] PH_RC_SCL_L = 5'd28;
    localparam logic [PH_W-1:0] PH_RC_D     = 5'd29;

    // configuration registers
    logic [imbe_pkg::HALF_W-1:0]  half_reg;
    logic [imbe_pkg::REC_W-1:0]   rec_reg;

    // engine state
    logic [PH_W-1:0]               phase_reg, phase_next;
    logic                          started_reg, started_next;
    logic [CNT_W-1:0]              bit_cnt_reg, bit_cnt_next;
    logic [imbe_pkg::DATA_W-1:0]   shift_reg, shift_next;
    logic [imbe_pkg::HALF_W-1:0]   wait_reg, wait_next;
    logic [imbe_pkg::REC_W-1:0]    high_run_reg, high_run_next;
    logic                          fl_stop_reg, fl_stop_next;
    logic                          fl_nack_reg, fl_nack_next;
    logic                          fl_rec_reg, fl_rec_next;
    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic                          nack_reg, nack_next;
    logic [imbe_pkg::DATA_W-1:0]   rd_byte_reg, rd_byte_next;
    logic                          done_reg, done_next;
    logic                          out_valid_reg;

    logic                          accept;
    logic [imbe_pkg::HALF_W-1:0]   half_eff;
    logic [imbe_pkg::REC_W-1:0]    rec_eff;
    logic [imbe_pkg::HALF_W:0]     wait_inc;
    logic                          wait_done;
    logic [imbe_pkg::REC_W:0]      run_inc;
    logic                          run_done;
    logic [PH_W-1:0]               wait_target;
    logic                          in_wait;

    // handshake: the state registers double as the result register
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // delay and recovery counters; zero settings count as one
    assign half_eff  = (half_reg == '0) ? {{(imbe_pkg::HALF_W-1){1'b0}}, 1'b1} : half_reg;
    assign rec_eff   = (rec_reg == '0) ? {{(imbe_pkg::REC_W-1){1'b0}}, 1'b1} : rec_reg;
    assign wait_inc  = {1'b0, wait_reg} + {{imbe_pkg::HALF_W{1'b0}}, 1'b1};
    assign wait_done = wait_inc >= {1'b0, half_eff};
    assign run_inc   = {1'b0, high_run_reg} + {{imbe_pkg::REC_W{1'b0}}, 1'b1};
    assign run_done  = run_inc >= {1'b0, rec_eff};

    // next state for one tick
    always_comb
    begin
        phase_next    = phase_reg;
        started_next  = started_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        wait_next     = wait_reg;
        high_run_next = high_run_reg;
        fl_stop_next  = fl_stop_reg;
        fl_nack_next  = fl_nack_reg;
        fl_rec_next   = fl_rec_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        nack_next     = nack_reg;
        rd_byte_next  = rd_byte_reg;
        done_next     = 1'b0;
        in_wait       = 1'b0;
        wait_target   = PH_IDLE;

        unique case (phase_reg)
            PH_IDLE:
            begin
                wait_next    = '0;
                bit_cnt_next = '0;
                unique case (cmd)
                    imbe_pkg::CMD_WRITE:
                    begin
                        shift_next   = write_data;
                        fl_stop_next = want_stop;
                        fl_nack_next = 1'b0;
                        fl_rec_next  = 1'b0;
                        if (want_start)
                        begin
                            phase_next = started_reg ? PH_RS_SDA_H : PH_ST_SDA_L;
                        end
                        else
                        begin
                            phase_next = PH_WB_SDA;
                        end
                    end
                    imbe_pkg::CMD_READ:
                    begin
                        shift_next   = '0;
                        fl_stop_next = want_stop;
                        fl_nack_next = send_nack;
                        fl_rec_next  = 1'b0;
                        phase_next   = PH_RB_SDA_H;
                    end
                    imbe_pkg::CMD_RECOVER:
                    begin
                        fl_stop_next  = 1'b0;
                        fl_nack_next  = 1'b0;
                        fl_rec_next   = 1'b1;
                        high_run_next = '0;
                        phase_next    = PH_RC_SCL_L;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            // repeated START
            PH_RS_SDA_H: begin sda_next = 1'b1; phase_next = PH_RS_D1; end
            PH_RS_D1:    begin in_wait = 1'b1; wait_target = PH_RS_SCL_H; end
            PH_RS_SCL_H: begin scl_next = 1'b1; phase_next = PH_RS_STR; end
            PH_RS_STR:   begin if (scl_in) phase_next = PH_RS_D2; end
            PH_RS_D2:    begin in_wait = 1'b1; wait_target = PH_ST_SDA_L; end
            // START
            PH_ST_SDA_L: begin sda_next = 1'b0; phase_next = PH_ST_D; end
            PH_ST_D:     begin in_wait = 1'b1; wait_target = PH_ST_SCL_L; end
            PH_ST_SCL_L:
            begin
                scl_next     = 1'b0;
                started_next = 1'b1;
                phase_next   = PH_WB_SDA;
            end
            // drive one bit: data MSB first, or the read acknowledge
            PH_WB_SDA:
            begin
                sda_next   = (bit_cnt_reg < BITS_PER_BYTE) ? shift_reg[imbe_pkg::DATA_W-1]
                                                           : fl_nack_reg;
                phase_next = PH_WB_D1;
            end
            PH_WB_D1:    begin in_wait = 1'b1; wait_target = PH_WB_SCL_H; end
            PH_WB_SCL_H: begin scl_next = 1'b1; phase_next = PH_WB_D2; end
            PH_WB_D2:    begin in_wait = 1'b1; wait_target = PH_WB_STR; end
            PH_WB_STR:   begin if (scl_in) phase_next = PH_WB_SCL_L; end
            PH_WB_SCL_L:
            begin
                scl_next = 1'b0;
                if (bit_cnt_reg < BITS_PER_BYTE)
                begin
                    shift_next   = {shift_reg[imbe_pkg::DATA_W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    phase_next   = (bit_cnt_next == BITS_PER_BYTE) ? PH_RB_SDA_H : PH_WB_SDA;
                end
                else if (fl_stop_reg)
                begin
                    phase_next = PH_SP_SDA_L;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            // sample one bit: data, write acknowledge, or recovery probe
            PH_RB_SDA_H: begin sda_next = 1'b1; phase_next = PH_RB_D1; end
            PH_RB_D1:    begin in_wait = 1'b1; wait_target = PH_RB_SCL_H; end
            PH_RB_SCL_H: begin scl_next = 1'b1; phase_next = PH_RB_STR; end
            PH_RB_STR:   begin if (scl_in) phase_next = PH_RB_D2; end
            PH_RB_D2:    begin in_wait = 1'b1; wait_target = PH_RB_SMP; end
            PH_RB_SMP:
            begin
                scl_next = 1'b0;
                if (fl_rec_reg)
                begin
                    if (sda_in && run_done)
                    begin
                        high_run_next = '0;
                        phase_next    = PH_SP_SDA_L;
                    end
                    else
                    begin
                        high_run_next = sda_in ? run_inc[imbe_pkg::REC_W-1:0] : '0;
                        phase_next    = PH_RB_SDA_H;
                    end
                end
                else if (bit_cnt_reg < BITS_PER_BYTE)
                begin
                    shift_next   = {shift_reg[imbe_pkg::DATA_W-2:0], sda_in};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    if (bit_cnt_next == BITS_PER_BYTE)
                    begin
                        rd_byte_next = shift_next;
                        phase_next   = PH_WB_SDA;
                    end
                    else
                    begin
                        phase_next = PH_RB_SDA_H;
                    end
                end
                else
                begin
                    nack_next = sda_in;
                    if (fl_stop_reg)
                    begin
                        phase_next = PH_SP_SDA_L;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            // STOP
            PH_SP_SDA_L: begin sda_next = 1'b0; phase_next = PH_SP_D1; end
            PH_SP_D1:    begin in_wait = 1'b1; wait_target = PH_SP_SCL_H; end
            PH_SP_SCL_H: begin scl_next = 1'b1; phase_next = PH_SP_STR; end
            PH_SP_STR:   begin if (scl_in) phase_next = PH_SP_D2; end
            PH_SP_D2:    begin in_wait = 1'b1; wait_target = PH_SP_SDA_H; end
            PH_SP_SDA_H: begin sda_next = 1'b1; phase_next = PH_SP_D3; end
            PH_SP_D3:
            begin
                in_wait     = 1'b1;
                wait_target = PH_IDLE;
                if (wait_done)
                begin
                    started_next = 1'b0;
                    done_next    = 1'b1;
                end
            end
            // recovery entry: hold SCL low for one delay
            PH_RC_SCL_L: begin scl_next = 1'b0; phase_next = PH_RC_D; end
            PH_RC_D:     begin in_wait = 1'b1; wait_target = PH_RB_SDA_H; end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // shared delay step
        if (in_wait)
        begin
            if (wait_done)
            begin
                wait_next  = '0;
                phase_next = wait_target;
            end
            else
            begin
                wait_next = wait_inc[imbe_pkg::HALF_W-1:0];
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= imbe_pkg::HALF_PERIOD_RESET;
            rec_reg  <= imbe_pkg::RECOVER_CNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imbe_pkg::CFG_HALF_PERIOD: half_reg <= cfg_data;
                imbe_pkg::CFG_RECOVER_CNT: rec_reg  <= cfg_data[imbe_pkg::REC_W-1:0];
                default: ;
            endcase
        end
    end

    // engine state, updated once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            started_reg  <= 1'b0;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            wait_reg     <= '0;
            high_run_reg <= '0;
            fl_stop_reg  <= 1'b0;
            fl_nack_reg  <= 1'b0;
            fl_rec_reg   <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            nack_reg     <= 1'b0;
            rd_byte_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            started_reg  <= started_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            wait_reg     <= wait_next;
            high_run_reg <= high_run_next;
            fl_stop_reg  <= fl_stop_next;
            fl_nack_reg  <= fl_nack_next;
            fl_rec_reg   <= fl_rec_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            nack_reg     <= nack_next;
            rd_byte_reg  <= rd_byte_next;
            done_reg     <= done_next;
        end
    end

    // result valid: set by a request, cleared once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = scl_reg;
    assign sda_out   = sda_reg;
    assign busy_res  = (phase_reg != PH_IDLE);
    assign done_res  = done_reg;
    assign read_data = rd_byte_reg;
    assign got_nack  = nack_reg;

endmodule

// ----- sv/imbe_checker.sv -----
module imbe_assertions
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        scl_out,
    input  logic                        sda_out,
    input  logic                        busy_res,
    input  logic                        done_res,
    input  logic [imbe_pkg::DATA_W-1:0] read_data,
    input  logic                        got_nack
);

    // a completing tick always leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done shown while still busy");

    // requests are held back only by a result that is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled with no result pending");

    // completion never repeats on the next tick
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && !out_stall |=> !(out_valid && done_res))
        else $error("done on two consecutive results");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scl_out) && $stable(sda_out)
            && $stable(busy_res) && $stable(done_res) && $stable(read_data)
            && $stable(got_nack))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_top imbe_assertions u_imbe_assertions
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scl_out   (scl_out),
    .sda_out   (sda_out),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .read_data (read_data),
    .got_nack  (got_nack)
);
